// ----- rtl/iert_pkg.sv -----
`timescale 1ns / 1ps

package iert_pkg;

  localparam int TABLE_DEPTH = 64;
  localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

  localparam logic [7:0]  ECHO_REPLY_TYPE = 8'd0;
  localparam logic [27:0] LEN_UNDER_MIN   = 28'd0;   // length bits 3 and up all zero means < 8
  localparam logic [31:0] USEC_PER_SEC    = 32'd1000000;
  localparam logic [31:0] USEC_PER_MS     = 32'd1000;

  // quotient bits of a microsecond magnitude below 2^20 divided by 1000
  localparam int DIV_STEPS = 11;
  localparam int STEP_W    = $clog2(DIV_STEPS);

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_SHORT    = 3'd1,
    ST_MISMATCH = 3'd2,
    ST_RANGE    = 3'd3,
    ST_FULL     = 3'd4
  } status_t;

  typedef enum logic {
    KIND_SEND  = 1'b0,
    KIND_REPLY = 1'b1
  } kind_t;

  typedef struct packed {
    status_t          status;
    logic [15:0]      sequence_res;
    logic [15:0]      icmp_length;
    logic [31:0]      round_trip_ms;
    logic [CNT_W-1:0] sent_total;
    logic [31:0]      received_total;
  } result_t;

  typedef struct packed {
    logic    load;
    result_t data;
  } res_load_t;

endpackage

// ----- rtl/iert_if.sv -----
`timescale 1ns / 1ps

interface iert_req_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [31:0] now_seconds;
  logic [19:0] now_microseconds;
  logic [3:0]  ip_header_words;
  logic [15:0] received_length;
  logic [7:0]  message_type;
  logic [15:0] message_identifier;
  logic [15:0] message_sequence;

  modport source (
    output valid, kind, now_seconds, now_microseconds, ip_header_words,
           received_length, message_type, message_identifier, message_sequence,
    input  ready
  );
  modport sink (
    input  valid, kind, now_seconds, now_microseconds, ip_header_words,
           received_length, message_type, message_identifier, message_sequence,
    output ready
  );
endinterface

interface iert_res_if;
  logic                          valid;
  logic                          ready;
  logic [2:0]                    status;
  logic [15:0]                   sequence_res;
  logic [15:0]                   icmp_length;
  logic signed [31:0]            round_trip_ms;
  logic [iert_pkg::CNT_W-1:0]    sent_total;
  logic [31:0]                   received_total;

  modport source (
    output valid, status, sequence_res, icmp_length, round_trip_ms, sent_total,
           received_total,
    input  ready
  );
  modport sink (
    input  valid, status, sequence_res, icmp_length, round_trip_ms, sent_total,
           received_total,
    output ready
  );
endinterface

// ----- rtl/iert_alu.sv -----
`timescale 1ns / 1ps

module iert_alu (
  input  logic [31:0] a,
  input  logic [31:0] b,
  input  logic        sub,
  output logic [31:0] res
);

  logic [31:0] b_eff;

  assign b_eff = sub ? ~b : b;
  assign res   = a + b_eff + {31'd0, sub};

endmodule

// ----- rtl/iert_core.sv -----
`timescale 1ns / 1ps

module iert_core (
  input  logic                clk,
  input  logic                rst,
  iert_req_if.sink            req,
  input  logic [15:0]         own_identifier,
  input  logic                out_free,
  output iert_pkg::res_load_t res_load
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_LEN,
    S_SEC,
    S_USEC,
    S_BOR_S,
    S_BOR_U,
    S_ABS,
    S_DIV,
    S_QNEG,
    S_MUL_A,
    S_MUL_B,
    S_SUM,
    S_DONE
  } state_t;

  state_t state;

  logic [31:0] now_s;
  logic [19:0] now_us;
  logic [3:0]  hdr_words;
  logic [15:0] rx_len;
  logic [7:0]  mtype;
  logic [15:0] mid;
  logic [15:0] mseq;

  logic [iert_pkg::CNT_W-1:0] send_counter;
  logic [31:0]                reply_counter;

  logic [51:0] mem [iert_pkg::TABLE_DEPTH];
  logic [51:0] rd_data;

  logic [31:0] secs;
  logic [31:0] usecs;
  logic [31:0] quo;
  logic [31:0] acc;
  logic [iert_pkg::DIV_STEPS-1:0] q;
  logic                           neg;
  logic [iert_pkg::STEP_W-1:0]    step;

  iert_pkg::status_t status;
  logic [15:0]       seq_res;
  logic [15:0]       icmp_len;
  logic [31:0]       rtt;

  logic        accept;
  logic        table_full;
  logic [31:0] alu_a;
  logic [31:0] alu_b;
  logic        alu_sub;
  logic [31:0] alu_res;
  logic [31:0] div_b;
  logic        len_short;
  logic        id_bad;
  logic        seq_bad;
  logic        entry_written;

  assign req.ready  = (state == S_IDLE) && !rst;
  assign accept     = req.valid && req.ready;
  assign table_full = (32'(send_counter) >= 32'(iert_pkg::TABLE_DEPTH));
  assign div_b      = iert_pkg::USEC_PER_MS << step;

  // entries below the fill count hold a real time, others read as zero
  assign entry_written = (17'(mseq) < 17'(send_counter));
  assign len_short     = alu_res[31] || (alu_res[30:3] == {1'b0, iert_pkg::LEN_UNDER_MIN[26:0]});
  assign id_bad        = (mtype != iert_pkg::ECHO_REPLY_TYPE) || (mid != own_identifier);
  assign seq_bad       = (17'(mseq) >= 17'(iert_pkg::TABLE_DEPTH));

  always_comb begin
    alu_a   = '0;
    alu_b   = '0;
    alu_sub = 1'b0;
    case (state)
      S_LEN: begin
        alu_a   = 32'(rx_len);
        alu_b   = 32'({hdr_words, 2'b00});
        alu_sub = 1'b1;
      end
      S_SEC: begin
        alu_a   = now_s;
        alu_b   = secs;
        alu_sub = 1'b1;
      end
      S_USEC: begin
        alu_a   = 32'(now_us);
        alu_b   = usecs;
        alu_sub = 1'b1;
      end
      S_BOR_S: begin
        alu_a   = secs;
        alu_b   = 32'd1;
        alu_sub = 1'b1;
      end
      S_BOR_U: begin
        alu_a = usecs;
        alu_b = iert_pkg::USEC_PER_SEC;
      end
      S_ABS: begin
        alu_b   = usecs;
        alu_sub = 1'b1;
      end
      S_DIV: begin
        alu_a   = usecs;
        alu_b   = div_b;
        alu_sub = 1'b1;
      end
      S_QNEG: begin
        alu_b   = 32'(q);
        alu_sub = 1'b1;
      end
      // x*1000 = x*1024 - x*32 + x*8
      S_MUL_A: begin
        alu_a   = secs << 10;
        alu_b   = secs << 5;
        alu_sub = 1'b1;
      end
      S_MUL_B: begin
        alu_a = acc;
        alu_b = secs << 3;
      end
      S_SUM: begin
        alu_a = acc;
        alu_b = quo;
      end
      default: begin
        alu_a   = '0;
        alu_b   = '0;
        alu_sub = 1'b0;
      end
    endcase
  end

  iert_alu u_alu (
    .a   (alu_a),
    .b   (alu_b),
    .sub (alu_sub),
    .res (alu_res)
  );

  always_ff @(posedge clk) begin
    if (accept && (req.kind == iert_pkg::KIND_SEND) && !table_full) begin
      mem[send_counter[iert_pkg::IDX_W-1:0]] <= {req.now_seconds, req.now_microseconds};
    end
    if (accept && (req.kind == iert_pkg::KIND_REPLY)) begin
      rd_data <= mem[req.message_sequence[iert_pkg::IDX_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      send_counter  <= '0;
      reply_counter <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (accept) begin
            now_s     <= req.now_seconds;
            now_us    <= req.now_microseconds;
            hdr_words <= req.ip_header_words;
            rx_len    <= req.received_length;
            mtype     <= req.message_type;
            mid       <= req.message_identifier;
            mseq      <= req.message_sequence;
            icmp_len  <= '0;
            rtt       <= '0;
            if (req.kind == iert_pkg::KIND_SEND) begin
              seq_res <= 16'(send_counter);
              state   <= S_DONE;
              if (table_full) begin
                status <= iert_pkg::ST_FULL;
              end else begin
                status       <= iert_pkg::ST_OK;
                send_counter <= send_counter + iert_pkg::CNT_W'(1);
              end
            end else begin
              seq_res <= req.message_sequence;
              state   <= S_LEN;
            end
          end
        end
        S_LEN: begin
          icmp_len <= alu_res[31] ? 16'd0 : alu_res[15:0];
          secs     <= entry_written ? rd_data[51:20] : 32'd0;
          usecs    <= entry_written ? 32'(rd_data[19:0]) : 32'd0;
          if (len_short) begin
            status <= iert_pkg::ST_SHORT;
            state  <= S_DONE;
          end else if (id_bad) begin
            status <= iert_pkg::ST_MISMATCH;
            state  <= S_DONE;
          end else if (seq_bad) begin
            status <= iert_pkg::ST_RANGE;
            state  <= S_DONE;
          end else begin
            status        <= iert_pkg::ST_OK;
            reply_counter <= reply_counter + 32'd1;
            state         <= S_SEC;
          end
        end
        S_SEC: begin
          secs  <= alu_res;
          state <= S_USEC;
        end
        S_USEC: begin
          usecs <= alu_res;
          state <= alu_res[31] ? S_BOR_S : S_ABS;
        end
        S_BOR_S: begin
          secs  <= alu_res;
          state <= S_BOR_U;
        end
        S_BOR_U: begin
          usecs <= alu_res;
          state <= S_ABS;
        end
        S_ABS: begin
          // divide the magnitude, fix the sign afterwards (truncates toward zero)
          neg   <= usecs[31];
          usecs <= usecs[31] ? alu_res : usecs;
          q     <= '0;
          step  <= iert_pkg::STEP_W'(iert_pkg::DIV_STEPS - 1);
          state <= S_DIV;
        end
        S_DIV: begin
          q <= {q[iert_pkg::DIV_STEPS-2:0], ~alu_res[31]};
          if (!alu_res[31]) begin
            usecs <= alu_res;
          end
          if (step == '0) begin
            state <= S_QNEG;
          end else begin
            step <= step - iert_pkg::STEP_W'(1);
          end
        end
        S_QNEG: begin
          quo   <= neg ? alu_res : 32'(q);
          state <= S_MUL_A;
        end
        S_MUL_A: begin
          acc   <= alu_res;
          state <= S_MUL_B;
        end
        S_MUL_B: begin
          acc   <= alu_res;
          state <= S_SUM;
        end
        S_SUM: begin
          rtt   <= alu_res;
          state <= S_DONE;
        end
        S_DONE: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign res_load.load                = (state == S_DONE) && out_free;
  assign res_load.data.status         = status;
  assign res_load.data.sequence_res   = seq_res;
  assign res_load.data.icmp_length    = icmp_len;
  assign res_load.data.round_trip_ms  = rtt;
  assign res_load.data.sent_total     = send_counter;
  assign res_load.data.received_total = reply_counter;

endmodule

// ----- rtl/icmp_echo_reply_tracker.sv -----
`timescale 1ns / 1ps

// Echo request/reply tracker. A send request stores the current time at the next
// sequence number (64-entry timestamp memory) and returns that sequence; once all
// entries are used, sends return status table full. A reply request is checked for
// length, type, identifier and sequence range, and a good one returns the round trip
// in milliseconds. One request is worked on at a time, stepped by a sequencer that
// runs every subtraction (with a borrow step when the microsecond difference borrows
// a second), the shift-and-add multiply by 1000 and an 11-step divide by 1000
// through one shared 32-bit adder. A finished result sits in an output register,
// so the next request is taken while it waits. Write own_identifier only while no
// request is in flight.

module icmp_echo_reply_tracker (
  input  logic        clk,
  input  logic        rst,
  iert_req_if.sink    req,
  iert_res_if.source  res,
  input  logic        cfg_wr_en,
  input  logic [15:0] cfg_wr_data
);

  logic [15:0]         own_identifier;
  logic                out_free;
  iert_pkg::res_load_t res_load;
  iert_pkg::result_t   out_data;
  logic                out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      own_identifier <= '0;
    end else if (cfg_wr_en) begin
      own_identifier <= cfg_wr_data;
    end
  end

  assign out_free = !out_valid || res.ready;

  iert_core u_core (
    .clk            (clk),
    .rst            (rst),
    .req            (req),
    .own_identifier (own_identifier),
    .out_free       (out_free),
    .res_load       (res_load)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_load.load) begin
      out_valid <= 1'b1;
    end else if (res.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load.load) begin
      out_data <= res_load.data;
    end
  end

  assign res.valid          = out_valid;
  assign res.status         = out_data.status;
  assign res.sequence_res   = out_data.sequence_res;
  assign res.icmp_length    = out_data.icmp_length;
  assign res.round_trip_ms  = out_data.round_trip_ms;
  assign res.sent_total     = out_data.sent_total;
  assign res.received_total = out_data.received_total;

endmodule
